>>> sv/olsf_pkg.sv
// ----------------------------------------------------------------------------
// olsf_pkg: shared types and constants for the order late-supplier filter
// Field widths, the row and result word layouts, and the control struct
// passed from the order tracker to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package olsf_pkg;

  localparam int KEY_BITS   = 24;
  localparam int COUNT_BITS = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // One line-item row.
  typedef struct packed {
    key_t supp_key;
    logic is_late;
    logic supp_in_nation;
    logic order_is_final;
    logic last_of_order;
  } row_word_t;

  // One qualifying order.
  typedef struct packed {
    key_t   waiting_supplier;
    count_t wait_count;
  } result_word_t;

  // What the tracker concludes about the row it is given.
  typedef struct packed {
    logic         emit;
    result_word_t result;
  } decision_t;

endpackage

`default_nettype wire

>>> sv/olsf_row_if.sv
// ----------------------------------------------------------------------------
// olsf_row_if: valid/ready channel carrying line-item row words
// The source drives valid and data, the sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface olsf_row_if;
  logic                valid;
  logic                ready;
  olsf_pkg::row_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/olsf_result_if.sv
// ----------------------------------------------------------------------------
// olsf_result_if: valid/ready channel carrying result words
// The source drives valid and data, the sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface olsf_result_if;
  logic                   valid;
  logic                   ready;
  olsf_pkg::result_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/order_late_supplier_filter.sv
// ----------------------------------------------------------------------------
// order_late_supplier_filter: flags final orders with several suppliers whose
// late lines all come from one supplier in the target nation
// A row waits in the input register while it is judged; when it is stepped,
// the result register takes its result word, if it makes one.
// Throughput: one row word per cycle; the only stall is a held result word
// meeting a new result word.
// Reset: synchronous, active high; clears both valid flags and the order state.
// ----------------------------------------------------------------------------
`default_nettype none

module order_late_supplier_filter (
  input  wire           clk,
  input  wire           rst,
  olsf_row_if.sink      rows,
  olsf_result_if.source results
);

  // Stage one: the accepted row word, held while the tracker judges it until it moves on.
  logic                   row_valid;
  olsf_pkg::row_word_t    row_word;

  // Stage two: the result register toward the output channel.
  logic                   result_valid;
  olsf_pkg::result_word_t result_word;

  olsf_pkg::decision_t    decision;
  logic                   row_go;
  logic                   row_step;

  // The tracker looks at the row in stage one and, when that row is stepped,
  // folds it into the state of the order in flight.
  olsf_track u_track (
    .clk      (clk),
    .rst      (rst),
    .step     (row_step),
    .row      (row_word),
    .decision (decision)
  );

  // A row that makes no result always moves on. A row that makes one moves
  // on when the result register is empty or is being emptied in this cycle.
  assign row_go   = !decision.emit || !result_valid || results.ready;
  assign row_step = row_valid && row_go;

  // The input register is free when empty or when its word leaves now, so a
  // new row word can be taken every cycle in which the held word moves on.
  assign rows.ready = !row_valid || row_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (rows.ready) begin
      row_valid <= rows.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rows.ready && rows.valid) begin
      row_word <= rows.data;
    end
  end

  // The result register keeps its word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (row_step && decision.emit) begin
      result_valid <= 1'b1;
    end else if (results.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_step && decision.emit) begin
      result_word <= decision.result;
    end
  end

  assign results.valid = result_valid;
  assign results.data  = result_word;

endmodule

`default_nettype wire

>>> sv/olsf_track.sv
// ----------------------------------------------------------------------------
// olsf_track: running per-order flags and the end-of-order decision
// Holds the state of the order in flight, judges the presented row
// combinationally, and commits the new state when the row is stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module olsf_track (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  olsf_pkg::row_word_t  row,
  output olsf_pkg::decision_t  decision
);

  logic             first_seen;
  olsf_pkg::key_t   first_key;
  logic             several_suppliers;
  logic             late_seen;
  olsf_pkg::key_t   late_key;
  logic             many_late;
  logic             late_in_nation;
  olsf_pkg::count_t late_total;

  logic             first_seen_next;
  olsf_pkg::key_t   first_key_next;
  logic             several_suppliers_next;
  logic             late_seen_next;
  olsf_pkg::key_t   late_key_next;
  logic             many_late_next;
  logic             late_in_nation_next;
  olsf_pkg::count_t late_total_next;

  always_comb begin
    first_seen_next        = 1'b1;
    first_key_next         = first_seen ? first_key : row.supp_key;
    several_suppliers_next = several_suppliers |
                             (first_seen && (row.supp_key != first_key));

    late_seen_next      = late_seen;
    late_key_next       = late_key;
    many_late_next      = many_late;
    late_in_nation_next = late_in_nation;
    late_total_next     = late_total;
    if (row.is_late) begin
      if (!late_seen) begin
        late_seen_next      = 1'b1;
        late_key_next       = row.supp_key;
        late_in_nation_next = row.supp_in_nation;
        late_total_next     = olsf_pkg::COUNT_ONE;
      end else if (row.supp_key != late_key) begin
        many_late_next = 1'b1;
      end else if (late_total != olsf_pkg::COUNT_MAX) begin
        late_total_next = late_total + olsf_pkg::COUNT_ONE;
      end
    end
  end

  always_comb begin
    decision.emit = row.last_of_order && row.order_is_final && several_suppliers_next &&
                    late_seen_next && !many_late_next && late_in_nation_next;
    decision.result.waiting_supplier = late_key_next;
    decision.result.wait_count       = late_total_next;
  end

  // The last row of an order clears everything for the next one.
  always_ff @(posedge clk) begin
    if (rst || (step && row.last_of_order)) begin
      first_seen        <= 1'b0;
      first_key         <= '0;
      several_suppliers <= 1'b0;
      late_seen         <= 1'b0;
      late_key          <= '0;
      many_late         <= 1'b0;
      late_in_nation    <= 1'b0;
      late_total        <= '0;
    end else if (step) begin
      first_seen        <= first_seen_next;
      first_key         <= first_key_next;
      several_suppliers <= several_suppliers_next;
      late_seen         <= late_seen_next;
      late_key          <= late_key_next;
      many_late         <= many_late_next;
      late_in_nation    <= late_in_nation_next;
      late_total        <= late_total_next;
    end
  end

endmodule

`default_nettype wire
